[hdl/foa_pkg.sv]
// frame owner allocator package
// request and result payload types, function and status codes, scan event type
// no dependencies
package foa_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned MAP_W   = 64;
  localparam int unsigned IDX_W   = 6;

  localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RETRY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [ID_W-1:0]    proc_id;
    logic [COUNT_W-1:0] page_count;
  } foa_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [MAP_W-1:0]   frame_map;
    logic [COUNT_W-1:0] free_frames;
  } foa_rsp_t;

  typedef struct packed {
    logic              last;
    logic              hit;
    logic              inc;
    logic              dec;
    logic [IDX_W-1:0]  idx;
    logic [STAT_W-1:0] status;
  } foa_event_t;

endpackage

[hdl/foa_owner_mem.sv]
// owner tag memory, one write and one registered read port per cycle
// per-frame valid bits make never-written frames read as free (owner 0)
// depends on foa_pkg
module foa_owner_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [AW-1:0]            rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [AW-1:0]            wr_addr_i,
  input  logic [foa_pkg::ID_W-1:0] wr_data_i,
  output logic [foa_pkg::ID_W-1:0] rd_data_o
);

  logic [foa_pkg::ID_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]         vld_q;
  logic [foa_pkg::ID_W-1:0] rd_q;
  logic                     rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

[hdl/foa_ctrl.sv]
// sequencer and shared compare unit: checks the request, then walks the
// owner memory one frame per cycle and emits one event per frame, or for a
// rejected request skips the walk and emits one event; depends on foa_pkg
module foa_ctrl #(
  parameter int unsigned NUM_FRAMES = 64,
  parameter int unsigned AW         = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  foa_pkg::foa_req_t           req_i,
  input  logic [foa_pkg::COUNT_W-1:0] free_cnt_i,
  output logic                        busy_o,
  output logic                        rd_en_o,
  output logic [AW-1:0]               rd_addr_o,
  input  logic [foa_pkg::ID_W-1:0]    rd_data_i,
  output logic                        wr_en_o,
  output logic [AW-1:0]               wr_addr_o,
  output logic [foa_pkg::ID_W-1:0]    wr_data_o,
  output foa_pkg::foa_event_t         ev_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;

  localparam logic [AW:0]                   NF_A   = (AW+1)'(NUM_FRAMES);
  localparam logic [AW-1:0]                 LAST_A = AW'(NUM_FRAMES - 1);
  localparam logic [foa_pkg::COUNT_W-1:0]   NF_C   = foa_pkg::COUNT_W'(NUM_FRAMES);

  logic [1:0]                    state_q, state_d;
  logic [foa_pkg::FUNC_W-1:0]    func_q, func_d;
  logic [foa_pkg::ID_W-1:0]      id_q, id_d;
  logic [foa_pkg::COUNT_W-1:0]   cnt_q, cnt_d;
  logic [foa_pkg::COUNT_W-1:0]   granted_q, granted_d;
  logic [AW:0]                   rd_idx_q, rd_idx_d;
  logic                          ev_vld_q, ev_vld_d;
  logic [AW-1:0]                 ev_idx_q, ev_idx_d;
  logic [foa_pkg::STAT_W-1:0]    chk_status;

  always_comb begin
    chk_status = foa_pkg::ST_DONE;
    case (func_q)
      foa_pkg::FN_ALLOC: begin
        if (cnt_q == '0 || cnt_q > NF_C || id_q == '0) begin
          chk_status = foa_pkg::ST_INVALID;
        end else if (cnt_q > free_cnt_i) begin
          chk_status = foa_pkg::ST_RETRY;
        end
      end
      foa_pkg::FN_FREE:  chk_status = foa_pkg::ST_DONE;
      foa_pkg::FN_QUERY: chk_status = foa_pkg::ST_DONE;
      default:           chk_status = foa_pkg::ST_INVALID;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    id_d      = id_q;
    cnt_d     = cnt_q;
    granted_d = granted_q;
    rd_idx_d  = rd_idx_q;
    ev_vld_d  = ev_vld_q;
    ev_idx_d  = ev_idx_q;
    rd_en_o   = 1'b0;
    rd_addr_o = rd_idx_q[AW-1:0];
    wr_en_o   = 1'b0;
    wr_addr_o = ev_idx_q;
    wr_data_o = '0;
    ev_o      = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          func_d  = req_i.func;
          id_d    = req_i.proc_id;
          cnt_d   = req_i.page_count;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (chk_status != foa_pkg::ST_DONE) begin
          ev_o.last   = 1'b1;
          ev_o.status = chk_status;
          state_d     = S_IDLE;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = '0;
          rd_idx_d  = (AW+1)'(1);
          ev_vld_d  = 1'b1;
          ev_idx_d  = '0;
          granted_d = '0;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_idx_q < NF_A) begin
          rd_en_o  = 1'b1;
          ev_vld_d = 1'b1;
          ev_idx_d = rd_idx_q[AW-1:0];
          rd_idx_d = rd_idx_q + (AW+1)'(1);
        end else begin
          ev_vld_d = 1'b0;
        end
        if (ev_vld_q) begin
          ev_o.idx = foa_pkg::IDX_W'(ev_idx_q);
          if (func_q == foa_pkg::FN_ALLOC) begin
            if (rd_data_i == '0 && granted_q < cnt_q) begin
              ev_o.hit  = 1'b1;
              ev_o.dec  = 1'b1;
              wr_en_o   = 1'b1;
              wr_data_o = id_q;
              granted_d = granted_q + foa_pkg::COUNT_W'(1);
            end
          end else if (rd_data_i == id_q) begin
            ev_o.hit = 1'b1;
            if (func_q == foa_pkg::FN_FREE && id_q != '0) begin
              ev_o.inc = 1'b1;
              wr_en_o  = 1'b1;
            end
          end
          if (ev_idx_q == LAST_A) begin
            ev_o.last = 1'b1;
            ev_vld_d  = 1'b0;
            state_d   = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ev_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ev_vld_q <= ev_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    id_q      <= id_d;
    cnt_q     <= cnt_d;
    granted_q <= granted_d;
    rd_idx_q  <= rd_idx_d;
    ev_idx_q  <= ev_idx_d;
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

[hdl/frame_owner_allocator.sv]
// frame owner allocator top level: free count, result map and result register
// instantiates foa_ctrl and foa_owner_mem, depends on foa_pkg
//
// An operation is transferred when start_i is high and busy_o is low. Each one
// checks the request in the check state, then walks the owner memory at one
// frame per cycle through its single registered read port before done_o is
// strobed. A rejected request (invalid count, owner ID or function, or too few
// free frames) skips the walk and reports straight from the check state. The
// result is shown on rsp_o for the single cycle in which done_o is high and must
// be taken then; busy_o is already low in that cycle, so the next operation may
// be transferred alongside it.
module frame_owner_allocator #(
  parameter int unsigned NUM_FRAMES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  foa_pkg::foa_req_t  req_i,
  output logic               busy_o,
  output logic               done_o,
  output foa_pkg::foa_rsp_t  rsp_o
);

  localparam int unsigned AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [foa_pkg::ID_W-1:0]      rd_data;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [foa_pkg::ID_W-1:0]      wr_data;
  foa_pkg::foa_event_t           ev;

  logic [foa_pkg::COUNT_W-1:0]   free_q, free_d;
  logic [foa_pkg::MAP_W-1:0]     map_q, map_d;
  logic                          done_q;
  foa_pkg::foa_rsp_t             rsp_q;

  foa_ctrl #(
    .NUM_FRAMES (NUM_FRAMES),
    .AW         (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .free_cnt_i (free_q),
    .busy_o     (busy_o),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .ev_o       (ev)
  );

  foa_owner_mem #(
    .DEPTH (NUM_FRAMES),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  always_comb begin
    free_d = free_q + foa_pkg::COUNT_W'(ev.inc) - foa_pkg::COUNT_W'(ev.dec);
    map_d  = map_q;
    if (ev.hit) begin
      map_d = map_q | (foa_pkg::MAP_W'(1) << ev.idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= foa_pkg::COUNT_W'(NUM_FRAMES);
      done_q <= 1'b0;
    end else begin
      free_q <= free_d;
      done_q <= ev.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      map_q <= '0;
    end else begin
      map_q <= map_d;
    end
    if (ev.last) begin
      rsp_q.status      <= ev.status;
      rsp_q.frame_map   <= map_d;
      rsp_q.free_frames <= free_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done strobe lasted more than one cycle");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.free_frames <= foa_pkg::COUNT_W'(NUM_FRAMES))
    else $error("free count above frame total");

  a_reject_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != foa_pkg::ST_DONE) |-> rsp_o.frame_map == '0)
    else $error("rejected operation reported frames");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("transfer did not raise busy");

endmodule
